[rtl/erseq_pkg.sv]
// shared types and constants for the euclidean rhythm sequencer
// item structs for both channels, mode codes, reset onset count
// no dependencies
package erseq_pkg;

	localparam int SIZE_DEF     = 16;
	localparam int RESET_ONSETS = 7;
	localparam int RESET_W      = $clog2(RESET_ONSETS + 1);

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_INC  = 2'd1,
		MODE_DEC  = 2'd2,
		MODE_SET  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [4:0]  onset_value;
	} in_item_t;

	typedef struct packed {
		logic        fire;
		logic [4:0]  gap_length;
		logic [4:0]  onset_total;
	} out_item_t;

endpackage

[rtl/erseq_slot_gen.sv]
// christoffel word slot generator, one slot per step
// a single adder advances the balance term; period restarts on balance zero
// depends on erseq_pkg
module erseq_slot_gen #(
	parameter int SIZE = erseq_pkg::SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic step,
	input  logic [(($clog2(SIZE + 1) > erseq_pkg::RESET_W) ?
		$clog2(SIZE + 1) : erseq_pkg::RESET_W)-1:0] n,
	output logic slot
);

	localparam int CNT_W = ($clog2(SIZE + 1) > erseq_pkg::RESET_W) ?
		$clog2(SIZE + 1) : erseq_pkg::RESET_W;
	localparam int DW = CNT_W + 1;

	logic          start_q;
	logic [DW-1:0] d_q;
	logic [DW-1:0] neg_x;
	logic [DW-1:0] a_op;
	logic [DW-1:0] addend;
	logic [DW-1:0] sum;
	logic          d_pos;
	logic          d_zero;

	assign d_zero = (d_q == '0);
	assign d_pos  = !d_q[DW-1] && !d_zero;
	assign neg_x  = DW'(n) - DW'(SIZE);

	// shared adder: period start gives 2n - size, otherwise d - x or d + n
	assign a_op   = start_q ? DW'(n) : d_q;
	assign addend = (start_q || d_pos) ? neg_x : DW'(n);
	assign sum    = a_op + addend;

	always_comb begin
		if (n == '0) begin
			slot = 1'b0;
		end else if (n >= CNT_W'(SIZE)) begin
			slot = 1'b1;
		end else if (start_q) begin
			slot = 1'b1;
		end else if (!d_zero) begin
			slot = d_pos;
		end else begin
			slot = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else if (load) begin
			start_q <= 1'b1;
		end else if (step) begin
			if (start_q) begin
				start_q <= 1'b0;
			end else if (d_zero) begin
				// trailing zero written, period starts again
				start_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && (start_q || !d_zero)) begin
			d_q <= sum;
		end
	end

endmodule

[rtl/erseq_gap_ram.sv]
// gap table memory, one write port and one registered read port
// an entry holds the gap of an onset slot, zero for a rest
// depends on erseq_pkg for the default size
module erseq_gap_ram #(
	parameter int SIZE = erseq_pkg::SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(SIZE)-1:0]       waddr,
	input  logic [$clog2(SIZE + 1)-1:0]   wdata,
	input  logic [$clog2(SIZE)-1:0]       raddr,
	output logic [$clog2(SIZE + 1)-1:0]   rdata
);

	localparam int GW = $clog2(SIZE + 1);

	logic [GW-1:0] mem [SIZE];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/euclidean_rhythm_sequencer.sv]
// Euclidean rhythm step sequencer over SIZE slots. A tick item goes from acceptance in
// S_IDLE via S_DONE into the output register, which waits while the receiver stalls; an item
// that leaves the onset count unchanged takes the same path. An item that changes the
// onset count rebuilds the gap table: S_LOAD loads the slot generator, S_BUILD walks the
// slots with its single adder and the one write port of the gap memory, S_DONE hands over
// the result. After reset the table for seven onsets is built the same way, so the input
// side is not ready until that build ends; rotation writes are taken at any time.
// Depends on erseq_pkg, erseq_slot_gen and erseq_gap_ram.
module euclidean_rhythm_sequencer #(
	parameter int SIZE = erseq_pkg::SIZE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  erseq_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output erseq_pkg::out_item_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [3:0]           cfg_data
);

	localparam int PW    = $clog2(SIZE);
	localparam int GW    = $clog2(SIZE + 1);
	localparam int CNT_W = (GW > erseq_pkg::RESET_W) ? GW : erseq_pkg::RESET_W;
	localparam int NW    = (CNT_W > 5) ? CNT_W : 5;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_LOAD  = 4'b0010,
		S_BUILD = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [PW-1:0]        pos_q;
	logic [PW-1:0]        rot_q;
	logic [PW-1:0]        point_q;
	logic                 tick_q;
	logic                 pend_q;
	logic [CNT_W-1:0]     j_q;
	logic [PW-1:0]        last_q;
	logic                 last_vld_q;
	logic                 out_valid_q;
	erseq_pkg::out_item_t out_q;

	logic                 accept;
	logic                 is_tick;
	logic [PW-1:0]        rot_red;
	logic [PW:0]          diff;
	logic [PW-1:0]        point;
	logic [NW-1:0]        cnt_w;
	logic [NW-1:0]        nn;
	logic [NW-1:0]        nn_sat;
	logic [CNT_W-1:0]     new_cnt;
	logic                 slot;
	logic                 walk_end;
	logic                 gen_load;
	logic                 gen_step;
	logic                 ram_we;
	logic [PW-1:0]        ram_waddr;
	logic [GW-1:0]        ram_wdata;
	logic [PW-1:0]        ram_raddr;
	logic [GW-1:0]        ram_rdata;
	logic                 out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_tick   = (in_data.mode == erseq_pkg::MODE_TICK);
	assign cfg_ready = 1'b1;

	// rotation modulo size, a sixteen entry table
	always_comb begin
		rot_red = '0;
		for (int k = 0; k < 16; k++) begin
			if (cfg_data == 4'(k)) begin
				rot_red = PW'(k % SIZE);
			end
		end
	end

	// slot read by a tick: position minus rotation, wrapped
	always_comb begin
		diff = {1'b0, pos_q} - {1'b0, rot_q};
		if (diff[PW]) begin
			point = PW'(diff + (PW + 1)'(SIZE));
		end else begin
			point = diff[PW-1:0];
		end
	end

	// next onset count, saturated to size
	always_comb begin
		cnt_w = NW'(cnt_q);
		case (in_data.mode)
			erseq_pkg::MODE_INC: nn = (cnt_w < NW'(SIZE)) ? cnt_w + 1'b1 : cnt_w;
			erseq_pkg::MODE_DEC: nn = (cnt_w != '0) ? cnt_w - 1'b1 : cnt_w;
			erseq_pkg::MODE_SET: nn = NW'(in_data.onset_value);
			default:             nn = cnt_w;
		endcase
		nn_sat  = (nn > NW'(SIZE)) ? NW'(SIZE) : nn;
		new_cnt = CNT_W'(nn_sat);
	end

	// table walk: a rest writes zero at its own slot, an onset closes the gap
	// of the previous onset, the final step closes the last gap at pattern end
	assign walk_end  = (j_q == CNT_W'(SIZE));
	assign gen_load  = (state_q == S_LOAD);
	assign gen_step  = (state_q == S_BUILD) && !walk_end;
	assign ram_we    = (state_q == S_BUILD) && ((walk_end || slot) ? last_vld_q : 1'b1);
	assign ram_waddr = (walk_end || slot) ? last_q : j_q[PW-1:0];
	assign ram_wdata = (walk_end || slot) ? GW'(j_q - CNT_W'(last_q)) : '0;
	assign ram_raddr = (state_q == S_IDLE) ? point : point_q;

	erseq_slot_gen #(
		.SIZE (SIZE)
	) u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (gen_load),
		.step   (gen_step),
		.n      (cnt_q),
		.slot   (slot)
	);

	erseq_gap_ram #(
		.SIZE (SIZE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			cnt_q      <= CNT_W'(erseq_pkg::RESET_ONSETS);
			pos_q      <= '0;
			rot_q      <= '0;
			tick_q     <= 1'b0;
			pend_q     <= 1'b0;
			j_q        <= '0;
			last_vld_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				rot_q <= rot_red;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						tick_q <= is_tick;
						pend_q <= 1'b1;
						if (is_tick) begin
							pos_q   <= (pos_q == PW'(SIZE - 1)) ? '0 : pos_q + 1'b1;
							state_q <= S_DONE;
						end else if (new_cnt != cnt_q) begin
							cnt_q   <= new_cnt;
							state_q <= S_LOAD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_LOAD: begin
					j_q        <= '0;
					last_vld_q <= 1'b0;
					state_q    <= S_BUILD;
				end
				S_BUILD: begin
					if (walk_end) begin
						state_q <= pend_q ? S_DONE : S_IDLE;
					end else begin
						if (slot) begin
							last_vld_q <= 1'b1;
						end
						j_q <= j_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_load) begin
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			point_q <= point;
		end
		if (gen_step && slot) begin
			last_q <= j_q[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.fire        <= tick_q && (ram_rdata != '0);
			out_q.gap_length  <= tick_q ? 5'(ram_rdata) : 5'd0;
			out_q.onset_total <= 5'(cnt_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[tb/euclidean_rhythm_sequencer_test.sv]
// self-checking testbench for euclidean_rhythm_sequencer: an in-bench predictor of the
// onset pattern and gap table is checked against every result, under random stalls
// depends on erseq_pkg and the euclidean_rhythm_sequencer rtl
`timescale 1ns / 1ps

module euclidean_rhythm_sequencer_test;

	localparam int SIZE        = erseq_pkg::SIZE_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 242;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	erseq_pkg::in_item_t  in_data;
	logic                 out_valid;
	logic                 out_ready;
	erseq_pkg::out_item_t out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [3:0]           cfg_data;

	// predictor state
	int         onsets_now;
	int         step_now;
	int         rotation_now;
	bit         slot_onset [SIZE];
	logic [4:0] slot_gap [SIZE];

	erseq_pkg::out_item_t pending_beats [$];
	int         errors;
	int         beats_seen;
	int         cycle_count;
	int         ready_wait;
	int         stall_draw;
	bit         steady;

	euclidean_rhythm_sequencer #(.SIZE(SIZE)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// christoffel word of n ones over SIZE slots, shorter period repeated, then gaps
	function automatic void rebuild_slots(input int n);
		int a;
		int b;
		int len;
		int run;
		if (n == 0) begin
			for (int i = 0; i < SIZE; i++) begin
				slot_onset[i] = 1'b0;
				slot_gap[i]   = 5'd0;
			end
			return;
		end
		if (n >= SIZE) begin
			for (int i = 0; i < SIZE; i++) begin
				slot_onset[i] = 1'b1;
				slot_gap[i]   = 5'd1;
			end
			return;
		end
		a = n;
		b = SIZE - n;
		slot_onset[0] = 1'b1;
		len = 1;
		while (a != b && len < SIZE) begin
			if (a > b) begin
				slot_onset[len] = 1'b1;
				b += SIZE - n;
			end else begin
				slot_onset[len] = 1'b0;
				a += n;
			end
			len++;
		end
		if (len < SIZE) begin
			slot_onset[len] = 1'b0;
			len++;
		end
		for (int i = 0; i + len < SIZE; i++)
			slot_onset[i + len] = slot_onset[i];
		run = 1;
		for (int i = SIZE - 1; i >= 0; i--) begin
			if (slot_onset[i]) begin
				slot_gap[i] = run[4:0];
				run = 1;
			end else begin
				slot_gap[i] = 5'd0;
				run++;
			end
		end
	endfunction

	function automatic void apply_onsets(input int n);
		if (n > SIZE)
			n = SIZE;
		if (n != onsets_now) begin
			onsets_now = n;
			rebuild_slots(n);
		end
	endfunction

	function automatic erseq_pkg::out_item_t predict_beat(input erseq_pkg::in_item_t item);
		erseq_pkg::out_item_t res;
		int                   point;
		res = '0;
		case (item.mode)
			erseq_pkg::MODE_TICK: begin
				point = (step_now + SIZE - (rotation_now % SIZE)) % SIZE;
				step_now = (step_now + 1) % SIZE;
				res.fire       = slot_onset[point];
				res.gap_length = slot_gap[point];
			end
			erseq_pkg::MODE_INC:
				apply_onsets(onsets_now < SIZE ? onsets_now + 1 : onsets_now);
			erseq_pkg::MODE_DEC:
				apply_onsets(onsets_now > 0 ? onsets_now - 1 : 0);
			default:
				apply_onsets(int'(item.onset_value));
		endcase
		res.onset_total = onsets_now[4:0];
		return res;
	endfunction

	function automatic erseq_pkg::in_item_t make_item(input erseq_pkg::mode_t m,
		input logic [4:0] v);
		erseq_pkg::in_item_t item;
		item.mode        = m;
		item.onset_value = v;
		return item;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at beat %0d, %s: got %0d expected %0d",
			beats_seen, what, got, want);
		errors++;
	endtask

	// called at a rising edge; returns at the edge where the item is accepted
	task automatic send_item(input erseq_pkg::in_item_t item);
		int idle;
		idle = steady ? 0 : $urandom_range(0, 4);
		if (idle != 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		pending_beats.push_back(predict_beat(item));
	endtask

	// every item gives one result, so an empty queue plus the rebuild time means idle
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SIZE + 8) @(posedge clk);
	endtask

	task automatic write_rotation(input logic [3:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		rotation_now = int'(value);
	endtask

	// checks results against the predicted ones in order
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("unexpected result", int'(out_data), 0);
			end else begin
				if (out_data.fire !== pending_beats[0].fire)
					report_mismatch("fire", int'(out_data.fire),
						int'(pending_beats[0].fire));
				if (out_data.gap_length !== pending_beats[0].gap_length)
					report_mismatch("gap_length", int'(out_data.gap_length),
						int'(pending_beats[0].gap_length));
				if (out_data.onset_total !== pending_beats[0].onset_total)
					report_mismatch("onset_total", int'(out_data.onset_total),
						int'(pending_beats[0].onset_total));
				void'(pending_beats.pop_front());
			end
			beats_seen++;
		end
	end

	// receiver drops out_ready after each item it takes when a random draw is nonzero, never in a steady phase
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			stall_draw = steady ? 0 : $urandom_range(0, 4);
			if (stall_draw != 0) begin
				out_ready  <= 1'b0;
				ready_wait <= stall_draw;
			end
		end else if (!out_ready) begin
			if (ready_wait <= 1) begin
				out_ready  <= 1'b1;
				ready_wait <= 0;
			end else begin
				ready_wait <= ready_wait - 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** euclidean_rhythm_sequencer: FAILED **");
			$finish;
		end
	end

	// seven onsets straight out of reset
	task automatic test_reset_pattern();
		repeat (4) send_item(make_item(erseq_pkg::MODE_TICK, 5'd0));
	endtask

	// empty and full patterns, saturation both ways, unchanged count
	task automatic test_count_extremes();
		send_item(make_item(erseq_pkg::MODE_SET, 5'd0));
		send_item(make_item(erseq_pkg::MODE_TICK, 5'd31));
		send_item(make_item(erseq_pkg::MODE_TICK, 5'd0));
		send_item(make_item(erseq_pkg::MODE_SET, 5'd31));
		send_item(make_item(erseq_pkg::MODE_TICK, 5'd0));
		send_item(make_item(erseq_pkg::MODE_TICK, 5'd0));
		send_item(make_item(erseq_pkg::MODE_SET, 5'd16));
		send_item(make_item(erseq_pkg::MODE_INC, 5'd0));
		send_item(make_item(erseq_pkg::MODE_DEC, 5'd31));
		send_item(make_item(erseq_pkg::MODE_SET, 5'd0));
		send_item(make_item(erseq_pkg::MODE_DEC, 5'd0));
		send_item(make_item(erseq_pkg::MODE_INC, 5'd0));
		send_item(make_item(erseq_pkg::MODE_TICK, 5'd0));
		send_item(make_item(erseq_pkg::MODE_SET, 5'd15));
		send_item(make_item(erseq_pkg::MODE_TICK, 5'd0));
		send_item(make_item(erseq_pkg::MODE_SET, 5'd8));
		send_item(make_item(erseq_pkg::MODE_TICK, 5'd0));
	endtask

	task automatic test_rotation_extremes();
		settle();
		write_rotation(4'd15);
		send_item(make_item(erseq_pkg::MODE_TICK, 5'd0));
		send_item(make_item(erseq_pkg::MODE_TICK, 5'd0));
		settle();
		write_rotation(4'd0);
		send_item(make_item(erseq_pkg::MODE_TICK, 5'd0));
	endtask

	// mostly ticks so whole patterns get walked, with count changes mixed in
	task automatic run_random_phase(input int count);
		erseq_pkg::in_item_t item;
		int                  r;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			item.onset_value = 5'($urandom_range(0, 31));
			if (r < 58) begin
				item.mode = erseq_pkg::MODE_TICK;
			end else if (r < 72) begin
				item.mode = erseq_pkg::MODE_INC;
			end else if (r < 86) begin
				item.mode = erseq_pkg::MODE_DEC;
			end else begin
				item.mode = erseq_pkg::MODE_SET;
				if ($urandom_range(0, 3) == 0)
					item.onset_value = $urandom_range(0, 1) ? 5'd16 : 5'd0;
				else if ($urandom_range(0, 3) == 0)
					item.onset_value = 5'($urandom_range(17, 31));
			end
			send_item(item);
		end
		steady = 1'b0;
	endtask

	task automatic test_random();
		settle();
		write_rotation(4'd15);
		run_random_phase(PHASE_ITEMS);
		settle();
		write_rotation(4'd0);
		run_random_phase(PHASE_ITEMS);
		for (int p = 0; p < 4; p++) begin
			settle();
			write_rotation(4'($urandom_range(1, 14)));
			run_random_phase(PHASE_ITEMS);
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_ready    = 1'b1;
		cfg_valid    = 1'b0;
		cfg_data     = 4'd0;
		errors       = 0;
		beats_seen   = 0;
		cycle_count  = 0;
		ready_wait   = 0;
		stall_draw   = 0;
		steady       = 1'b0;
		onsets_now   = erseq_pkg::RESET_ONSETS;
		step_now     = 0;
		rotation_now = 0;
		rebuild_slots(erseq_pkg::RESET_ONSETS);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_pattern();
		test_count_extremes();
		test_rotation_extremes();
		test_random();
		settle();

		if (errors == 0)
			$display("** euclidean_rhythm_sequencer: PASSED **");
		else
			$display("** euclidean_rhythm_sequencer: FAILED **");
		$finish;
	end

endmodule

[files.f]
rtl/erseq_pkg.sv
rtl/erseq_slot_gen.sv
rtl/erseq_gap_ram.sv
rtl/euclidean_rhythm_sequencer.sv
tb/euclidean_rhythm_sequencer_test.sv
